/* hw/rtl/rrsc_pkg.sv */
// Shared constants, types and trig table for the radar ray scan converter.
package rrsc_pkg;

    localparam int BINS            = 400;
    localparam int MAX_RAY_SAMPLES = 4096;
    localparam int SAMPLE_BITS     = 12;
    localparam int IMG_CENTER      = 400;
    localparam int UNIT_SHIFT      = 15;
    localparam int DEG_FULL        = 360;
    localparam int DEG_HALF        = 180;
    localparam int DEG_3QTR        = 270;
    localparam int DEG_QUARTER     = 90;

    localparam int ANGLE_W    = 9;
    localparam int LEN_W      = 13;
    localparam int SAMPLE_W   = 12;
    localparam int COORD_W    = 10;
    localparam int INTENS_W   = 8;
    localparam int IDX_W      = $clog2(MAX_RAY_SAMPLES);
    localparam int BIN_W      = $clog2(BINS);
    localparam int DIVIDEND_W = IDX_W + BIN_W;
    localparam int MAG_W      = UNIT_SHIFT + 1;
    localparam int PROD_W     = BIN_W + MAG_W;
    localparam int QIDX_W     = 7;
    localparam int S_TDATA_W  = ((ANGLE_W + LEN_W + SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((2 * COORD_W + INTENS_W + 7) / 8) * 8;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } trig_t;

    localparam logic [MAG_W-1:0] QSIN [0:DEG_QUARTER] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
        16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
        16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
        16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
        16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
        16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
        16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
        16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
        16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
        16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
        16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
    };

    function automatic logic [MAG_W-1:0] qsin_lookup(input logic [QIDX_W-1:0] idx);
        logic [MAG_W-1:0] r;
        r = '0;
        if (idx <= QIDX_W'(DEG_QUARTER)) begin
            r = QSIN[idx];
        end
        return r;
    endfunction

    // signed sine for an angle already reduced to 0..359
    function automatic trig_t sine_of(input logic [ANGLE_W-1:0] a);
        trig_t            t;
        logic [ANGLE_W-1:0] d;
        if (a <= ANGLE_W'(DEG_QUARTER)) begin
            d     = a;
            t.neg = 1'b0;
        end else if (a <= ANGLE_W'(DEG_HALF)) begin
            d     = ANGLE_W'(DEG_HALF) - a;
            t.neg = 1'b0;
        end else if (a <= ANGLE_W'(DEG_3QTR)) begin
            d     = a - ANGLE_W'(DEG_HALF);
            t.neg = 1'b1;
        end else begin
            d     = ANGLE_W'(DEG_FULL) - a;
            t.neg = 1'b1;
        end
        t.mag = qsin_lookup(d[QIDX_W-1:0]);
        return t;
    endfunction

endpackage

/* hw/rtl/radar_ray_scan_converter_top.sv */
// Top level of the radar ray scan converter: sequencer, bin state and output register.
//
//  channel  | direction | tdata (low bit up)                      | tlast
//  s_       | in        | angle_deg[8:0] ray_length[21:9]         | last_sample
//           |           | sample[33:22] zero[39:34]               |
//  m_       | out       | pixel_x[9:0] pixel_y[19:10]             | last_of_ray
//           |           | intensity[27:20] zero[31:28]            |
//
// Steps: the divider gives one quotient bit per cycle, and its quotient becomes the bin;
//   the bin state is then updated, and a word with one pixel write runs the coordinate
//   unit and loads the output register. A second pixel write runs the coordinate unit
//   and the output load once more. A new sample word is taken only back in S_IDLE.
// A sample at or past the ray length, or of zero length, skips the divider (bin saturates).
// Reset: aresetn low for one edge clears sequencer, bin state and output valid.
// Stalls: m_tready low holds a finished word in the output register; the next
//   sample word is still taken, and a pixel load waits in S_OUT while it is full.
module radar_ray_scan_converter_top
    import rrsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // angle_deg, ray_length, sample, zero pad
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // pixel_x, pixel_y, intensity, zero pad
    output logic                 m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_DECIDE, S_CSTART, S_COORD, S_OUT, S_FINISH
    } state_t;

    // field positions inside s_tdata
    localparam int LEN_LO = ANGLE_W;
    localparam int SMP_LO = ANGLE_W + LEN_W;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg,   idx_next;
    logic [BIN_W-1:0]    cur_reg,   cur_next;
    logic [SAMPLE_W-1:0] peak_reg,  peak_next;

    logic [ANGLE_W-1:0]  ang_reg,   ang_next;
    logic [SAMPLE_W-1:0] smp_reg,   smp_next;
    logic                last_reg,  last_next;
    logic [BIN_W-1:0]    bin_reg,   bin_next;

    logic [BIN_W-1:0]    em_bin_reg,  em_bin_next;
    logic [SAMPLE_W-1:0] em_peak_reg, em_peak_next;
    logic                em_last_reg, em_last_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [COORD_W-1:0]  px_reg,       px_next;
    logic [COORD_W-1:0]  py_reg,       py_next;
    logic [INTENS_W-1:0] int_reg,      int_next;
    logic                mlast_reg,    mlast_next;

    logic                  s_accept;
    logic [ANGLE_W-1:0]    in_angle;
    logic [ANGLE_W-1:0]    in_angle_mod;
    logic [LEN_W-1:0]      in_len;
    logic [SAMPLE_W-1:0]   in_smp;
    logic                  in_sat;
    logic [DIVIDEND_W-1:0] dividend;
    logic                  div_start;
    logic                  div_done;
    logic [BIN_W-1:0]      div_quo;
    logic                  coord_start;
    logic                  coord_done;
    logic [COORD_W-1:0]    coord_x;
    logic [COORD_W-1:0]    coord_y;
    logic                  out_load;
    logic                  out_room;

    always_comb begin
        in_angle     = s_tdata[ANGLE_W-1:0];
        in_len       = s_tdata[LEN_LO +: LEN_W];
        in_smp       = s_tdata[SMP_LO +: SAMPLE_W] & SAMPLE_W'((1 << SAMPLE_BITS) - 1);
        in_angle_mod = (in_angle >= ANGLE_W'(DEG_FULL)) ? (in_angle - ANGLE_W'(DEG_FULL))
                                                        : in_angle;
        // a zero length, or an index at or past the length, saturates to the last bin
        in_sat       = (in_len == '0) || ({{(LEN_W - IDX_W){1'b0}}, idx_reg} >= in_len);
        dividend     = DIVIDEND_W'(idx_reg * BINS);
        s_accept     = s_tvalid && s_tready;
        div_start    = s_accept && !in_sat;
        coord_start  = (state_reg == S_CSTART);
        out_room     = !m_tvalid_reg || m_tready;
        out_load     = (state_reg == S_OUT) && out_room;
    end

    rrsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (in_len),
        .done     (div_done),
        .quotient (div_quo)
    );

    rrsc_coord u_coord (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (coord_start),
        .angle   (ang_reg),
        .bin     (em_bin_reg),
        .done    (coord_done),
        .pixel_x (coord_x),
        .pixel_y (coord_y)
    );

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cur_next      = cur_reg;
        peak_next     = peak_reg;
        ang_next      = ang_reg;
        smp_next      = smp_reg;
        last_next     = last_reg;
        bin_next      = bin_reg;
        em_bin_next   = em_bin_reg;
        em_peak_next  = em_peak_reg;
        em_last_next  = em_last_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        int_next      = int_reg;
        mlast_next    = mlast_reg;
        // drop valid once the word is taken; a load below sets it again
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    ang_next   = in_angle_mod;
                    smp_next   = in_smp;
                    last_next  = s_tlast;
                    bin_next   = BIN_W'(BINS - 1);
                    state_next = in_sat ? S_DECIDE : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    bin_next   = div_quo;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (idx_reg == '0) begin
                    // first sample of a ray opens its bin
                    cur_next     = bin_reg;
                    peak_next    = smp_reg;
                    em_bin_next  = bin_reg;
                    em_peak_next = smp_reg;
                    em_last_next = 1'b1;
                    state_next   = last_reg ? S_CSTART : S_FINISH;
                end else if (bin_reg != cur_reg) begin
                    // bin change: write the finished bin, then open the new one
                    em_bin_next  = cur_reg;
                    em_peak_next = peak_reg;
                    em_last_next = 1'b0;
                    cur_next     = bin_reg;
                    peak_next    = smp_reg;
                    state_next   = S_CSTART;
                end else begin
                    if (smp_reg > peak_reg) begin
                        peak_next = smp_reg;
                    end
                    em_bin_next  = cur_reg;
                    em_peak_next = (smp_reg > peak_reg) ? smp_reg : peak_reg;
                    em_last_next = 1'b1;
                    state_next   = last_reg ? S_CSTART : S_FINISH;
                end
            end
            S_CSTART: begin
                state_next = S_COORD;
            end
            S_COORD: begin
                if (coord_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_room) begin
                    px_next       = coord_x;
                    py_next       = coord_y;
                    int_next      = em_peak_reg[INTENS_W-1:0];
                    mlast_next    = em_last_reg;
                    m_tvalid_next = 1'b1;
                    if (!em_last_reg && last_reg) begin
                        // end of ray after a bin change: write the closing bin too
                        em_bin_next  = cur_reg;
                        em_peak_next = peak_reg;
                        em_last_next = 1'b1;
                        state_next   = S_CSTART;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (last_reg) begin
                    idx_next  = '0;
                    cur_next  = '0;
                    peak_next = '0;
                end else if (idx_reg == IDX_W'(MAX_RAY_SAMPLES - 1)) begin
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            cur_reg      <= '0;
            peak_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cur_reg      <= cur_next;
            peak_reg     <= peak_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ang_reg     <= ang_next;
        smp_reg     <= smp_next;
        last_reg    <= last_next;
        bin_reg     <= bin_next;
        em_bin_reg  <= em_bin_next;
        em_peak_reg <= em_peak_next;
        em_last_reg <= em_last_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        int_reg     <= int_next;
        mlast_reg   <= mlast_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({int_reg, py_reg, px_reg});
    assign m_tlast  = mlast_reg;

    // busy from the cycle after a sample word is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("sample word taken while previous one still in work");

    // a pixel load never overwrites a word that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten");

    // an in-range index goes through the divider
    a_div_path: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (state_reg == S_DIV))
        else $error("divider started outside the divide step");

    // end of ray returns the bin state to its reset values
    a_ray_end_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && last_reg) |=> (idx_reg == '0 && peak_reg == '0))
        else $error("bin state not cleared at end of ray");

endmodule

/* hw/rtl/rrsc_div.sv */
// Restoring divider, one quotient bit per cycle, giving the bin index.
module rrsc_div
    import rrsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [LEN_W-1:0]      divisor,
    output logic                  done,
    output logic [BIN_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(BIN_W + 1);

    logic [LEN_W-1:0]  rem_reg,  rem_next;
    logic [BIN_W-1:0]  dsh_reg,  dsh_next;
    logic [BIN_W-1:0]  quo_reg,  quo_next;
    logic [LEN_W-1:0]  den_reg,  den_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              done_reg, done_next;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    shifted;

    // caller guarantees dividend < divisor * 2^BIN_W, so the top slice is below divisor
    always_comb begin
        shifted   = {rem_reg, dsh_reg[BIN_W-1]};
        trial     = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = LEN_W'(dividend[DIVIDEND_W-1:BIN_W]);
            dsh_next = dividend[BIN_W-1:0];
            quo_next = '0;
            den_next = divisor;
            cnt_next = CNT_W'(BIN_W);
        end else if (cnt_reg != '0) begin
            if (!trial[LEN_W]) begin
                rem_next = trial[LEN_W-1:0];
            end else begin
                rem_next = shifted[LEN_W-1:0];
            end
            quo_next  = {quo_reg[BIN_W-2:0], ~trial[LEN_W]};
            dsh_next  = {dsh_reg[BIN_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/rrsc_coord.sv */
// Pixel coordinate unit: one shared multiplier, sine pass then cosine pass.
module rrsc_coord
    import rrsc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ANGLE_W-1:0] angle,
    input  logic [BIN_W-1:0]   bin,
    output logic               done,
    output logic [COORD_W-1:0] pixel_x,
    output logic [COORD_W-1:0] pixel_y
);

    typedef enum logic [2:0] {C_IDLE, C_MUL_X, C_ADD_X, C_MUL_Y, C_ADD_Y} cstate_t;

    cstate_t            state_reg, state_next;
    logic [PROD_W-1:0]  prod_reg,  prod_next;
    logic               neg_reg,   neg_next;
    logic [COORD_W-1:0] x_reg,     x_next;
    logic [COORD_W-1:0] y_reg,     y_next;
    logic               done_reg,  done_next;
    logic [ANGLE_W:0]   cos_sum;
    logic [ANGLE_W-1:0] cos_angle;
    trig_t              sin_t;
    trig_t              cos_t;
    trig_t              sel_t;
    logic [PROD_W:0]    rounded;
    logic [COORD_W-1:0] flr_mag;
    logic [COORD_W-1:0] centre;

    always_comb begin
        cos_sum   = {1'b0, angle} + (ANGLE_W + 1)'(DEG_QUARTER);
        cos_angle = (cos_sum >= (ANGLE_W + 1)'(DEG_FULL))
                    ? ANGLE_W'(cos_sum - (ANGLE_W + 1)'(DEG_FULL)) : cos_sum[ANGLE_W-1:0];
        sin_t     = sine_of(angle);
        cos_t     = sine_of(cos_angle);
        sel_t     = (state_reg == C_MUL_Y) ? cos_t : sin_t;
        // floor toward minus infinity: round the magnitude up when negative
        rounded   = neg_reg ? ({1'b0, prod_reg} + (PROD_W + 1)'((1 << UNIT_SHIFT) - 1))
                            : {1'b0, prod_reg};
        flr_mag   = COORD_W'(rounded >> UNIT_SHIFT);
        centre    = COORD_W'(IMG_CENTER);
    end

    always_comb begin
        state_next = state_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE: begin
                if (start) begin
                    state_next = C_MUL_X;
                end
            end
            C_MUL_X, C_MUL_Y: begin
                prod_next  = PROD_W'(bin * sel_t.mag);
                neg_next   = sel_t.neg;
                state_next = (state_reg == C_MUL_X) ? C_ADD_X : C_ADD_Y;
            end
            C_ADD_X: begin
                x_next     = neg_reg ? (centre - flr_mag) : (centre + flr_mag);
                state_next = C_MUL_Y;
            end
            C_ADD_Y: begin
                y_next     = neg_reg ? (centre + flr_mag) : (centre - flr_mag);
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
    end

    assign done    = done_reg;
    assign pixel_x = x_reg;
    assign pixel_y = y_reg;

endmodule
